FILE: rtl/phr_pkg.sv
// ----------------------------------------------------------------------------
// phr_pkg: shared types and constants of the pixel hue rotation unit
// Holds the pixel payload types, the pipeline record and fixed-point
// constants of the HSV conversion.
// ----------------------------------------------------------------------------
package phr_pkg;

    // Hue resolution: one degree is split into 2^HUE_FRAC_BITS steps.
    localparam int HUE_FRAC_BITS = 4;
    localparam int UNIT          = 60 << HUE_FRAC_BITS;
    localparam int SIX_UNIT      = 6 * UNIT;
    localparam int HUE_W         = 13;

    // Division steps of the two shared dividers.
    localparam int SAT_STEPS = 16;
    localparam int HUE_STEPS = 10;

    // floor(rem * 65536 / UNIT) as a multiply by reciprocal and a shift.
    localparam int F16_SHIFT = 14;
    localparam logic [20:0] F16_RECIP = 21'd1118482;

    // Register indexes.
    localparam int REG_HUE_SHIFT = 0;

    // Sector base codes of the hue rule.
    localparam logic [1:0] BASE_RED   = 2'd0;
    localparam logic [1:0] BASE_GREEN = 2'd1;
    localparam logic [1:0] BASE_BLUE  = 2'd2;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] in_alpha;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } pix_out_t;

    // Everything one pixel carries down the pipeline.
    typedef struct packed {
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [7:0]        alpha;
        logic              bypass;
        logic [7:0]        mx;
        logic [7:0]        delta;
        logic [7:0]        absdiff;
        logic              neg;
        logic [1:0]        base;
        logic [16:0]       v16;
        logic [16:0]       sq;
        logic [7:0]        sr;
        logic [9:0]        hq;
        logic [7:0]        hr;
        logic [9:0]        hlow;
        logic [16:0]       s16;
        logic [HUE_W-1:0]  h;
        logic [2:0]        sector;
        logic [9:0]        hrem;
        logic [15:0]       f16;
        logic [16:0]       p;
        logic [16:0]       q;
        logic [16:0]       t;
        logic [16:0]       sf;
        logic [16:0]       sfc;
    } pipe_t;

endpackage

FILE: rtl/phr_div_step.sv
// ----------------------------------------------------------------------------
// phr_div_step: one restoring step of the saturation and hue dividers
// Saturation divides delta*65536 by max; hue divides |diff|*UNIT by delta.
// ----------------------------------------------------------------------------
module phr_div_step
    import phr_pkg::*;
(
    input  pipe_t d_in,
    input  logic  hue_en,
    output pipe_t d_out
);

    logic [8:0] sat_rem2;
    logic [8:0] hue_rem2;

    // Saturation step: shift in a zero bit.
    assign sat_rem2 = {d_in.sr, 1'b0};
    // Hue step: shift in the next dividend bit.
    assign hue_rem2 = {d_in.hr, d_in.hlow[9]};

    always_comb
    begin
        d_out = d_in;
        if (sat_rem2 >= {1'b0, d_in.mx})
        begin
            d_out.sr = 8'(sat_rem2 - {1'b0, d_in.mx});
            d_out.sq = {d_in.sq[15:0], 1'b1};
        end
        else
        begin
            d_out.sr = sat_rem2[7:0];
            d_out.sq = {d_in.sq[15:0], 1'b0};
        end
        if (hue_en)
        begin
            d_out.hlow = {d_in.hlow[8:0], 1'b0};
            if (hue_rem2 >= {1'b0, d_in.delta})
            begin
                d_out.hr = 8'(hue_rem2 - {1'b0, d_in.delta});
                d_out.hq = {d_in.hq[8:0], 1'b1};
            end
            else
            begin
                d_out.hr = hue_rem2[7:0];
                d_out.hq = {d_in.hq[8:0], 1'b0};
            end
        end
    end

endmodule

FILE: rtl/pixel_hue_rotation_unit.sv
// ----------------------------------------------------------------------------
// pixel_hue_rotation_unit: rotates the hue of RGBA pixels by a set angle
// Throughput is one pixel per cycle while out_stall is low; each of the 25
// stages holds one pixel, and the restoring dividers use one quotient bit per stage.
// A stage whose successor is empty takes a new pixel even under output stall.
// Reset clears the valid bits and sets hue_shift to zero (pass-through).
// ----------------------------------------------------------------------------
module pixel_hue_rotation_unit
    import phr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  pix_in_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output pix_out_t    out_data
);

    localparam int NST     = 25;
    localparam int DIV_LO  = 2;
    localparam int ST_HFIN = DIV_LO + SAT_STEPS;
    localparam int ST_MOD  = ST_HFIN + 1;
    localparam int ST_SECT = ST_MOD + 1;
    localparam int ST_F16  = ST_SECT + 1;
    localparam int ST_PROD = ST_F16 + 1;
    localparam int ST_QT   = ST_PROD + 1;
    localparam int ST_OUT  = ST_QT + 1;

    logic [HUE_W-1:0] hue_shift_reg;
    pipe_t            st_reg  [NST];
    pipe_t            st_next [NST];
    logic [NST-1:0]   vld_reg;
    logic [NST:0]     en;

    // Configuration port: every write maps onto the one register.
    assign pready = 1'b1;
    assign prdata = {{(32-HUE_W){1'b0}}, hue_shift_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hue_shift_reg <= '0;
        else if (psel && penable && pwrite && pready)
            hue_shift_reg <= pwdata[HUE_W-1:0];
    end

    // Stage 0: max, min, delta and the signed hue difference.
    function automatic pipe_t f_ingest(pix_in_t px, logic [HUE_W-1:0] shift);
        pipe_t      d;
        logic [7:0] mn;
        logic [8:0] diff;
        d         = '0;
        d.red     = px.in_red;
        d.green   = px.in_green;
        d.blue    = px.in_blue;
        d.alpha   = px.in_alpha;
        d.bypass  = (shift == '0);
        d.mx      = px.in_red;
        mn        = px.in_red;
        if (px.in_green > d.mx) d.mx = px.in_green;
        if (px.in_blue > d.mx)  d.mx = px.in_blue;
        if (px.in_green < mn)   mn = px.in_green;
        if (px.in_blue < mn)    mn = px.in_blue;
        d.delta = d.mx - mn;
        if (px.in_red >= d.mx)
        begin
            d.base = BASE_RED;
            diff   = {1'b0, px.in_green} - {1'b0, px.in_blue};
        end
        else if (px.in_green >= d.mx)
        begin
            d.base = BASE_GREEN;
            diff   = {1'b0, px.in_blue} - {1'b0, px.in_red};
        end
        else
        begin
            d.base = BASE_BLUE;
            diff   = {1'b0, px.in_red} - {1'b0, px.in_green};
        end
        d.neg     = diff[8];
        d.absdiff = diff[8] ? 8'(-diff) : diff[7:0];
        return d;
    endfunction

    // Stage 1: value, divider seeds and the first saturation bit.
    function automatic pipe_t f_init(pipe_t a);
        pipe_t       d;
        logic [17:0] num;
        d     = a;
        // ceil(max * 65536 / 255) = max * 257 + (max != 0).
        d.v16 = 17'({a.mx, 8'd0} + {9'd0, a.mx} + {16'd0, (a.mx != 8'd0)});
        if ((a.mx != 8'd0) && (a.delta == a.mx))
        begin
            d.sq = 17'd1;
            d.sr = 8'd0;
        end
        else
        begin
            d.sq = 17'd0;
            d.sr = a.delta;
        end
        num    = {10'd0, a.absdiff} * 18'(UNIT);
        d.hr   = num[17:10];
        d.hlow = num[9:0];
        d.hq   = '0;
        return d;
    endfunction

    // Hue from sector base and quotient, wrapped into range.
    function automatic pipe_t f_hfin(pipe_t a);
        pipe_t                  d;
        logic signed [HUE_W+1:0] hv;
        d = a;
        d.s16 = (a.mx == 8'd0) ? 17'd0 : a.sq;
        hv = (HUE_W+2)'(a.base) * (HUE_W+2)'(2 * UNIT);
        if (a.neg)
            hv = hv - (HUE_W+2)'(a.hq);
        else
            hv = hv + (HUE_W+2)'(a.hq);
        if (hv < 0)
            hv = hv + (HUE_W+2)'(SIX_UNIT);
        d.h = (a.delta == 8'd0) ? '0 : hv[HUE_W-1:0];
        return d;
    endfunction

    // Add the shift and reduce below six sectors.
    function automatic pipe_t f_mod(pipe_t a, logic [HUE_W-1:0] shift);
        pipe_t           d;
        logic [HUE_W:0]  sum;
        d   = a;
        sum = {1'b0, a.h} + {1'b0, shift};
        if (sum >= (HUE_W+1)'(2 * SIX_UNIT))
            sum = sum - (HUE_W+1)'(2 * SIX_UNIT);
        else if (sum >= (HUE_W+1)'(SIX_UNIT))
            sum = sum - (HUE_W+1)'(SIX_UNIT);
        d.h = sum[HUE_W-1:0];
        return d;
    endfunction

    // Sector number and offset inside the sector.
    function automatic pipe_t f_sect(pipe_t a);
        pipe_t d;
        d = a;
        d.sector = 3'd5;
        d.hrem   = 10'(a.h - HUE_W'(5 * UNIT));
        for (int k = 4; k >= 0; k--)
        begin
            if (a.h < HUE_W'((k + 1) * UNIT))
            begin
                d.sector = 3'(k);
                d.hrem   = 10'(a.h - HUE_W'(k * UNIT));
            end
        end
        return d;
    endfunction

    // Fraction of the sector in 16 fraction bits.
    function automatic pipe_t f_frac(pipe_t a);
        pipe_t       d;
        logic [30:0] prod;
        d     = a;
        prod  = {21'd0, a.hrem} * F16_RECIP;
        d.f16 = prod[F16_SHIFT+15:F16_SHIFT];
        return d;
    endfunction

    // First products: P and the two scaled saturation terms.
    function automatic pipe_t f_prod(pipe_t a);
        pipe_t       d;
        logic [33:0] pp;
        logic [32:0] sfp;
        logic [32:0] sfcp;
        d     = a;
        pp    = a.v16 * (17'h10000 - a.s16);
        sfp   = a.s16 * {1'b0, a.f16};
        sfcp  = a.s16 * (17'h10000 - {1'b0, a.f16});
        d.p   = pp[32:16];
        d.sf  = sfp[32:16];
        d.sfc = sfcp[32:16];
        return d;
    endfunction

    // Second products: Q and T.
    function automatic pipe_t f_qt(pipe_t a);
        pipe_t       d;
        logic [33:0] qp;
        logic [33:0] tp;
        d   = a;
        qp  = a.v16 * (17'h10000 - a.sf);
        tp  = a.v16 * (17'h10000 - a.sfc);
        d.q = qp[32:16];
        d.t = tp[32:16];
        return d;
    endfunction

    function automatic logic [7:0] to_chan(logic [16:0] x);
        logic [24:0] m;
        m = {x, 8'd0} - {8'd0, x};
        return m[23:16];
    endfunction

    // Sector selection, scaling back to 8 bits, and bypass.
    function automatic pipe_t f_out(pipe_t a);
        pipe_t       d;
        logic [16:0] xr;
        logic [16:0] xg;
        logic [16:0] xb;
        d = a;
        case (a.sector)
            3'd0:    begin xr = a.v16; xg = a.t;   xb = a.p;   end
            3'd1:    begin xr = a.q;   xg = a.v16; xb = a.p;   end
            3'd2:    begin xr = a.p;   xg = a.v16; xb = a.t;   end
            3'd3:    begin xr = a.p;   xg = a.q;   xb = a.v16; end
            3'd4:    begin xr = a.t;   xg = a.p;   xb = a.v16; end
            default: begin xr = a.v16; xg = a.p;   xb = a.q;   end
        endcase
        if (!a.bypass)
        begin
            d.red   = to_chan(xr);
            d.green = to_chan(xg);
            d.blue  = to_chan(xb);
        end
        return d;
    endfunction

    // Next-state of every stage.
    assign st_next[0] = f_ingest(in_data, hue_shift_reg);
    assign st_next[1] = f_init(st_reg[0]);

    genvar gi;
    generate
        for (gi = 0; gi < SAT_STEPS; gi++)
        begin : g_div
            phr_div_step u_step (
                .d_in   (st_reg[DIV_LO+gi-1]),
                .hue_en ((gi < HUE_STEPS) ? 1'b1 : 1'b0),
                .d_out  (st_next[DIV_LO+gi])
            );
        end
    endgenerate

    assign st_next[ST_HFIN] = f_hfin(st_reg[ST_HFIN-1]);
    assign st_next[ST_MOD]  = f_mod(st_reg[ST_MOD-1], hue_shift_reg);
    assign st_next[ST_SECT] = f_sect(st_reg[ST_SECT-1]);
    assign st_next[ST_F16]  = f_frac(st_reg[ST_F16-1]);
    assign st_next[ST_PROD] = f_prod(st_reg[ST_PROD-1]);
    assign st_next[ST_QT]   = f_qt(st_reg[ST_QT-1]);
    assign st_next[ST_OUT]  = f_out(st_reg[ST_OUT-1]);

    // A stage loads when it is empty or its content moves on.
    assign en[NST] = !out_stall;
    generate
        for (gi = 0; gi < NST; gi++)
        begin : g_en
            assign en[gi] = !vld_reg[gi] || en[gi+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[0])
                vld_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NST; k++)
        begin
            if (en[k])
                st_reg[k] <= st_next[k];
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = vld_reg[NST-1];
    assign out_data  = '{out_red:   st_reg[NST-1].red,
                         out_green: st_reg[NST-1].green,
                         out_blue:  st_reg[NST-1].blue,
                         out_alpha: st_reg[NST-1].alpha};

    // The input side only stalls while the first stage is occupied.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> vld_reg[0])
        else $error("input stalled with an empty first stage");

    // A grey or black pixel leaves with equal channels.
    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && st_reg[NST-1].delta == 8'd0)
        |-> (out_data.out_red == out_data.out_green &&
             out_data.out_green == out_data.out_blue))
        else $error("grey pixel lost its grey level");

    // Saturation quotient never exceeds one.
    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_HFIN] |-> (st_reg[ST_HFIN].s16 <= 17'h10000))
        else $error("saturation out of range");

    // A stalled output holds while a new pixel moves into an emptied stage.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(st_reg[NST-1].alpha)))
        else $error("stalled output changed");

endmodule

FILE: tb/pixel_hue_rotation_unit_tb.sv
// ----------------------------------------------------------------------------
// pixel_hue_rotation_unit_tb: self-checking bench of the hue rotation unit
// Streams directed and random RGBA pixels through the unit under several
// hue shifts, predicts each output pixel in fixed point and compares every
// output transfer field by field, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pixel_hue_rotation_unit_tb;
    import phr_pkg::*;

    localparam int LATENCY     = 25;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_PIXELS = 1350;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    pix_in_t     in_data;
    logic        out_valid;
    logic        out_stall;
    pix_out_t    out_data;

    // Local copy of the rotation register.
    logic [12:0] shift_reg;
    pix_out_t    rotated_q[$];
    int          errors;
    int          cycles;
    int          pixels_sent;
    int          pixels_seen;
    bit          drain_stalls;

    typedef struct {
        logic [7:0] r, g, b, a;
        logic       known;
        logic [7:0] er, eg, eb;
    } row_t;

    pixel_hue_rotation_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    always #5 clk = ~clk;

    // Channel value of one fixed-point intensity.
    function automatic logic [7:0] chan8(longint x);
        return 8'((x * 255) >>> 16);
    endfunction

    // Fixed-point HSV round trip with the hue advanced by the shift.
    function automatic pix_out_t rotate_pixel(pix_in_t px, logic [12:0] sh);
        pix_out_t res;
        int       r, g, b, mx, mn, dl, h, hs, sect;
        longint   v16, s16, f16, p, q, t, xr, xg, xb;
        r = px.in_red;
        g = px.in_green;
        b = px.in_blue;
        res.out_alpha = px.in_alpha;
        if (sh == 0)
        begin
            res.out_red   = px.in_red;
            res.out_green = px.in_green;
            res.out_blue  = px.in_blue;
            return res;
        end
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        dl  = mx - mn;
        v16 = (longint'(mx) * 65536 + 254) / 255;
        s16 = (mx > 0) ? (longint'(dl) * 65536) / mx : 0;
        h   = 0;
        if (dl > 0)
        begin
            // Integer division truncates toward zero, as the hue rule needs.
            if (r >= mx)      h = ((g - b) * UNIT) / dl;
            else if (g >= mx) h = 2 * UNIT + ((b - r) * UNIT) / dl;
            else              h = 4 * UNIT + ((r - g) * UNIT) / dl;
            if (h < 0) h += SIX_UNIT;
        end
        hs   = (h + int'(sh)) % SIX_UNIT;
        sect = hs / UNIT;
        f16  = (longint'(hs % UNIT) * 65536) / UNIT;
        p = (v16 * (65536 - s16)) >>> 16;
        q = (v16 * (65536 - ((s16 * f16) >>> 16))) >>> 16;
        t = (v16 * (65536 - ((s16 * (65536 - f16)) >>> 16))) >>> 16;
        case (sect)
            0:       begin xr = v16; xg = t;   xb = p;   end
            1:       begin xr = q;   xg = v16; xb = p;   end
            2:       begin xr = p;   xg = v16; xb = t;   end
            3:       begin xr = p;   xg = q;   xb = v16; end
            4:       begin xr = t;   xg = p;   xb = v16; end
            default: begin xr = v16; xg = p;   xb = q;   end
        endcase
        res.out_red   = chan8(xr);
        res.out_green = chan8(xg);
        res.out_blue  = chan8(xb);
        return res;
    endfunction

    // Gap length: mostly short, now and then long.
    function automatic int gap_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45) return 0;
        if (sel < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // One register write through setup and access cycles.
    task automatic write_shift(logic [12:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 2'(REG_HUE_SHIFT * 4);
        pwdata  <= 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shift_reg = val;
        // The register takes the new value at the access edge; read it back after.
        @(posedge clk);
        if (prdata[12:0] !== val)
        begin
            $display("%0t: shift readback expected %0d actual %0d", $time, val, prdata[12:0]);
            errors++;
        end
    endtask

    // Drive one pixel transfer, with an optional gap first.
    task automatic send_pixel(pix_in_t px, bit with_gap);
        int n;
        n = with_gap ? gap_len() : 0;
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        rotated_q.push_back(rotate_pixel(px, shift_reg));
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pixels_sent++;
    endtask

    // Wait for the pipe to empty before touching the register.
    task automatic drain();
        in_valid <= 1'b0;
        while (rotated_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // Output side: random stall pattern and result checking.
    initial
    begin
        int n;
        out_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            n = gap_len();
            if (drain_stalls && n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        pix_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            pixels_seen++;
            if (rotated_q.size() == 0)
            begin
                $display("%0t: unexpected pixel %h", $time, out_data);
                errors++;
            end
            else
            begin
                want = rotated_q.pop_front();
                if (out_data.out_red !== want.out_red)
                begin
                    $display("%0t: red expected %0d actual %0d", $time,
                             want.out_red, out_data.out_red);
                    errors++;
                end
                if (out_data.out_green !== want.out_green)
                begin
                    $display("%0t: green expected %0d actual %0d", $time,
                             want.out_green, out_data.out_green);
                    errors++;
                end
                if (out_data.out_blue !== want.out_blue)
                begin
                    $display("%0t: blue expected %0d actual %0d", $time,
                             want.out_blue, out_data.out_blue);
                    errors++;
                end
                if (out_data.out_alpha !== want.out_alpha)
                begin
                    $display("%0t: alpha expected %0d actual %0d", $time,
                             want.out_alpha, out_data.out_alpha);
                    errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus.
    initial
    begin
        row_t        rows[$];
        row_t        rw;
        pix_in_t     px;
        pix_out_t    typed;
        logic [12:0] shifts[6];
        int          sel;
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0; in_data = '0;
        shift_reg = '0;
        errors = 0; cycles = 0; pixels_sent = 0; pixels_seen = 0;
        drain_stalls = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows at reset shift (bypass), then with a shift.
        rows = '{
            '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00},
            '{8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 8'hff, 8'hff, 8'hff},
            '{8'h12, 8'h9a, 8'hc3, 8'h55, 1'b1, 8'h12, 8'h9a, 8'hc3},
            '{8'hff, 8'h00, 8'h00, 8'haa, 1'b1, 8'hff, 8'h00, 8'h00}
        };
        foreach (rows[i])
        begin
            rw = rows[i];
            px = '{rw.r, rw.g, rw.b, rw.a};
            typed = '{rw.er, rw.eg, rw.eb, rw.a};
            if (rotate_pixel(px, shift_reg) !== typed)
            begin
                $display("%0t: row %0d expected %h actual %h", $time, i,
                         typed, rotate_pixel(px, shift_reg));
                errors++;
            end
            send_pixel(px, 1'b0);
        end
        drain();

        // Extremes and grey pixels under a 120 degree shift; greys are typed.
        write_shift(13'd1920);
        rows = '{
            '{8'h00, 8'h00, 8'h00, 8'h01, 1'b1, 8'h00, 8'h00, 8'h00},
            '{8'h80, 8'h80, 8'h80, 8'hfe, 1'b1, 8'h80, 8'h80, 8'h80},
            '{8'hff, 8'hff, 8'hff, 8'h7f, 1'b1, 8'hff, 8'hff, 8'hff},
            '{8'hff, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
            '{8'h00, 8'hff, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
            '{8'h00, 8'h00, 8'hff, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
            '{8'hff, 8'hff, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
            '{8'hff, 8'h00, 8'hff, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
            '{8'h00, 8'hff, 8'hff, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
            '{8'h01, 8'h00, 8'h02, 8'h33, 1'b0, 8'h00, 8'h00, 8'h00},
            '{8'hfe, 8'hff, 8'h01, 8'hcc, 1'b0, 8'h00, 8'h00, 8'h00}
        };
        foreach (rows[i])
        begin
            rw = rows[i];
            px = '{rw.r, rw.g, rw.b, rw.a};
            if (rw.known)
            begin
                typed = '{rw.er, rw.eg, rw.eb, rw.a};
                if (rotate_pixel(px, shift_reg) !== typed)
                begin
                    $display("%0t: row %0d expected %h actual %h", $time, i,
                             typed, rotate_pixel(px, shift_reg));
                    errors++;
                end
            end
            send_pixel(px, 1'b0);
        end
        drain();

        // Random phases over several shifts, extremes and out-of-range included.
        shifts = '{13'd1, 13'd5759, 13'd5760, 13'd8191, 13'd0, 13'd0};
        shifts[5] = 13'($urandom_range(1, 5759));
        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph < 6) write_shift(shifts[ph]);
            else write_shift(13'($urandom_range(0, 8191)));
            drain_stalls = (ph != 2);
            for (int k = 0; k < RAND_PIXELS / 7; k++)
            begin
                sel = $urandom_range(0, 9);
                px = pix_in_t'($urandom);
                if (sel == 0)
                begin
                    px.in_green = px.in_red;
                    px.in_blue  = px.in_red;
                end
                else if (sel == 1)
                begin
                    px.in_red = 8'hff;
                    px.in_blue = 8'h00;
                end
                send_pixel(px, ph != 3);
            end
            drain();
        end

        $display("Sent %0d pixels and checked %0d outputs over eight rotation settings.",
                 pixels_sent, pixels_seen);
        if (errors == 0 && rotated_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
